@@ rtl/core/iis_pkg.sv @@
// ----------------------------------------------------------------------------
// iis_pkg
// Shared widths, register indexes and stage types of the integral image
// streamer.
// ----------------------------------------------------------------------------
`default_nettype none

package iis_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int PIX_W       = 8;
  localparam int PIX_SQ_W    = 2 * PIX_W;
  localparam int SUM_W       = 28;
  localparam int SQ_W        = 36;
  localparam int RSUM_W      = 18;
  localparam int RSQ_W       = 27;
  localparam int POS_W       = 10;
  localparam int CFG_W       = 11;
  localparam int CFG_INDEX_W = 1;
  localparam int SIZE_W      = 13;

  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 11'd1024;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [RSUM_W-1:0] rsum;
    logic [RSQ_W-1:0]  rsq;
    logic [POS_W-1:0]  column;
    logic [POS_W-1:0]  row;
    logic              last_of_frame;
    logic              top_row;
  } stage_t;

  // map 0 to 1 and anything above the limit to the limit
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_W-1:0]  v,
                                                   input logic [SIZE_W-1:0] lim);
    logic [SIZE_W-1:0] ext;
    ext = SIZE_W'(v);
    if (ext == '0) begin
      return SIZE_W'(1);
    end else if (ext > lim) begin
      return lim;
    end
    return ext;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/iis_if.sv @@
// ----------------------------------------------------------------------------
// iis_if
// Valid/ready channels for pixel items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface iis_pixel_if;
  import iis_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface iis_result_if;
  import iis_pkg::*;
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] area_sum;
  logic [SQ_W-1:0]  area_sum_sq;
  logic [POS_W-1:0] column;
  logic [POS_W-1:0] row;
  logic             last_of_frame;

  modport source (output valid, output area_sum, output area_sum_sq, output column,
                  output row, output last_of_frame, input ready);
  modport sink   (input valid, input area_sum, input area_sum_sq, input column,
                  input row, input last_of_frame, output ready);
endinterface

`default_nettype wire

@@ rtl/core/integral_image_streamer_unit.sv @@
// ----------------------------------------------------------------------------
// integral_image_streamer_unit
// Raster-order integral image and squared integral image with a line store.
// ----------------------------------------------------------------------------
// Taken items pass the read stage, then the output stage. One line store read and one
// write per item; one item per cycle while the receiver takes result items.
// Reset clears counters, row sums and pipeline valids; both size registers
// return to 1024. The line store keeps no reset and needs no clearing pass.
`default_nettype none

module integral_image_streamer_unit import iis_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data,
  iis_pixel_if.sink                   pixel_in,
  iis_result_if.source                result_out
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic             adv;
  logic             take;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    s1_addr;
  logic             s1_valid;
  stage_t           s1;
  logic [SUM_W-1:0] rd_sum;
  logic [SQ_W-1:0]  rd_sq;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [SUM_W-1:0] wr_sum;
  logic [SQ_W-1:0]  wr_sq;

  assign pixel_in.ready = adv;
  assign take           = pixel_in.valid && adv;

  iis_scan #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .take     (take),
    .adv      (adv),
    .pixel    (pixel_in.pixel),
    .rd_addr  (rd_addr),
    .s1_addr  (s1_addr),
    .s1_valid (s1_valid),
    .s1       (s1)
  );

  iis_ram #(
    .WIDTH(SUM_W),
    .DEPTH(MAX_WIDTH)
  ) u_ram_sum (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_sum),
    .re   (take),
    .raddr(rd_addr),
    .rdata(rd_sum)
  );

  iis_ram #(
    .WIDTH(SQ_W),
    .DEPTH(MAX_WIDTH)
  ) u_ram_sq (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_sq),
    .re   (take),
    .raddr(rd_addr),
    .rdata(rd_sq)
  );

  iis_merge #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .rd_addr   (rd_addr),
    .s1_addr   (s1_addr),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .rd_sum    (rd_sum),
    .rd_sq     (rd_sq),
    .adv       (adv),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_sum    (wr_sum),
    .wr_sq     (wr_sq),
    .result_out(result_out)
  );

  a_take_fills_stage: assert property (@(posedge clk) disable iff (rst)
    take |=> s1_valid)
    else $error("taken item did not reach the read stage");

  a_write_gives_result: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> result_out.valid)
    else $error("line store write without a result item");

  a_write_only_on_advance: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (s1_valid && (!result_out.valid || result_out.ready)))
    else $error("line store written while the result is held");

endmodule

`default_nettype wire

@@ rtl/core/iis_ram.sv @@
// ----------------------------------------------------------------------------
// iis_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module iis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/iis_scan.sv @@
// ----------------------------------------------------------------------------
// iis_scan
// Size registers, raster counters, running row sums and the read stage.
// ----------------------------------------------------------------------------
`default_nettype none

module iis_scan import iis_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [CFG_INDEX_W-1:0]       cfg_index,
  input  wire logic [CFG_W-1:0]             cfg_data,
  input  wire logic                         take,
  input  wire logic                         adv,
  input  wire logic [PIX_W-1:0]             pixel,
  output      logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  output      logic [$clog2(MAX_WIDTH)-1:0] s1_addr,
  output      logic                         s1_valid,
  output      stage_t                       s1
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [CFG_W-1:0]  image_width;
  logic [CFG_W-1:0]  image_height;
  logic [AW-1:0]     col;
  logic [RW-1:0]     row;
  logic [RSUM_W-1:0] rsum;
  logic [RSQ_W-1:0]  rsq;

  logic [SIZE_W-1:0]   w_eff;
  logic [SIZE_W-1:0]   h_eff;
  logic                row_end;
  logic                frame_end;
  logic [PIX_SQ_W-1:0] pix_sq;
  logic [RSUM_W-1:0]   rsum_next;
  logic [RSQ_W-1:0]    rsq_next;

  always_comb begin
    w_eff     = clamp_size(image_width, SIZE_W'(MAX_WIDTH));
    h_eff     = clamp_size(image_height, SIZE_W'(MAX_HEIGHT));
    row_end   = (SIZE_W'(col) + SIZE_W'(1)) >= w_eff;
    frame_end = row_end && ((SIZE_W'(row) + SIZE_W'(1)) >= h_eff);
    pix_sq    = PIX_SQ_W'(pixel) * PIX_SQ_W'(pixel);
    rsum_next = rsum + RSUM_W'(pixel);
    rsq_next  = rsq + RSQ_W'(pix_sq);
    rd_addr   = col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_SIZE_RESET;
      image_height <= CFG_SIZE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      rsum <= '0;
      rsq  <= '0;
    end else if (take) begin
      if (row_end) begin
        col  <= '0;
        rsum <= '0;
        rsq  <= '0;
        row  <= frame_end ? '0 : row + RW'(1);
      end else begin
        col  <= col + AW'(1);
        rsum <= rsum_next;
        rsq  <= rsq_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_addr          <= col;
      s1.rsum          <= rsum_next;
      s1.rsq           <= rsq_next;
      s1.column        <= POS_W'(col);
      s1.row           <= POS_W'(row);
      s1.last_of_frame <= frame_end;
      s1.top_row       <= (row == '0);
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/iis_merge.sv @@
// ----------------------------------------------------------------------------
// iis_merge
// Adds the line store entry to the row sums, writes it back, forwards it to
// a read of the same entry and holds the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module iis_merge import iis_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         take,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] s1_addr,
  input  wire logic                         s1_valid,
  input  wire stage_t                       s1,
  input  wire logic [SUM_W-1:0]             rd_sum,
  input  wire logic [SQ_W-1:0]              rd_sq,
  output      logic                         adv,
  output      logic                         wr_en,
  output      logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  output      logic [SUM_W-1:0]             wr_sum,
  output      logic [SQ_W-1:0]              wr_sq,
  iis_result_if.source                      result_out
);

  logic             fwd_hit;
  logic [SUM_W-1:0] fwd_sum;
  logic [SQ_W-1:0]  fwd_sq;
  logic             out_valid;
  logic [SUM_W-1:0] out_sum;
  logic [SQ_W-1:0]  out_sq;
  logic [POS_W-1:0] out_column;
  logic [POS_W-1:0] out_row;
  logic             out_last;

  logic [SUM_W-1:0] above_sum;
  logic [SQ_W-1:0]  above_sq;

  always_comb begin
    if (s1.top_row) begin
      above_sum = '0;
      above_sq  = '0;
    end else if (fwd_hit) begin
      above_sum = fwd_sum;
      above_sq  = fwd_sq;
    end else begin
      above_sum = rd_sum;
      above_sq  = rd_sq;
    end
    adv     = !out_valid || result_out.ready;
    wr_en   = s1_valid && adv;
    wr_addr = s1_addr;
    wr_sum  = SUM_W'(s1.rsum) + above_sum;
    wr_sq   = SQ_W'(s1.rsq) + above_sq;
  end

  // bypass a write that lands on the entry being read in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (take) begin
      fwd_hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fwd_sum <= wr_sum;
      fwd_sq  <= wr_sq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      out_sum    <= wr_sum;
      out_sq     <= wr_sq;
      out_column <= s1.column;
      out_row    <= s1.row;
      out_last   <= s1.last_of_frame;
    end
  end

  assign result_out.valid         = out_valid;
  assign result_out.area_sum      = out_sum;
  assign result_out.area_sum_sq   = out_sq;
  assign result_out.column        = out_column;
  assign result_out.row           = out_row;
  assign result_out.last_of_frame = out_last;

endmodule

`default_nettype wire

@@ tb/sv/integral_image_streamer_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integral_image_streamer_unit_tb
// Checks the integral image streamer item by item against its own predictor
// of the running row sums and the line store of the row above. A short
// directed run covers size clamping, pixel extremes and size changes
// mid-row and mid-frame. A full 1024-pixel row follows, then many short
// random phases with random sizes and idling. The phases leave off at
// arbitrary points in the frame. During the full row and in some random
// phases, the receiver holds off long enough that the block backs up.
// ----------------------------------------------------------------------------
module integral_image_streamer_unit_tb;
  import iis_pkg::*;

  localparam int CYCLE_LIMIT       = 300000;
  localparam int STALL_CYCLES      = 300;
  localparam int SMALL_FRAME_ITEMS = 280;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [SUM_W-1:0] area_sum;
    logic [SQ_W-1:0]  area_sum_sq;
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
    logic             last_of_frame;
  } integral_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  iis_pixel_if  pixel_ch ();
  iis_result_if result_ch ();

  integral_image_streamer_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixel_in   (pixel_ch),
    .result_out (result_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [CFG_W-1:0]  width_reg = CFG_SIZE_RESET;
  logic [CFG_W-1:0]  height_reg = CFG_SIZE_RESET;
  logic [RSUM_W-1:0] run_sum = '0;
  logic [RSQ_W-1:0]  run_sq = '0;
  logic [SUM_W-1:0]  line_sum [MAX_WIDTH_DEF];
  logic [SQ_W-1:0]   line_sq [MAX_WIDTH_DEF];
  int unsigned       col_pos = 0;
  int unsigned       row_pos = 0;

  integral_t        expected_integrals [$];
  logic [PIX_W-1:0] pixel_queue [$];
  int unsigned      pixels_queued = 0;
  int unsigned      pixels_taken = 0;
  logic             pixel_taken = 1'b0;
  int unsigned      mismatches = 0;
  int unsigned      cycles = 0;
  idle_mode_t       idle_mode = IDLE_NONE;
  int unsigned      stall_requests = 0;
  int unsigned      stalls_served = 0;
  int unsigned      hold_left = 0;
  integral_t        want;

  function automatic int unsigned eff_size(input logic [CFG_W-1:0] v, input int unsigned lim);
    if (v == '0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  function automatic void integrate_pixel(input logic [PIX_W-1:0] p);
    int unsigned      w;
    int unsigned      h;
    int unsigned      c;
    logic [SUM_W-1:0] s;
    logic [SQ_W-1:0]  sq;
    logic             row_end;
    logic             frame_end;
    integral_t        entry;
    w = eff_size(width_reg, MAX_WIDTH_DEF);
    h = eff_size(height_reg, MAX_HEIGHT_DEF);
    c = (col_pos >= MAX_WIDTH_DEF) ? MAX_WIDTH_DEF - 1 : col_pos;
    run_sum = run_sum + RSUM_W'(p);
    run_sq = run_sq + RSQ_W'(p) * RSQ_W'(p);
    s = SUM_W'(run_sum);
    sq = SQ_W'(run_sq);
    if (row_pos > 0) begin
      s = s + line_sum[c];
      sq = sq + line_sq[c];
    end
    line_sum[c] = s;
    line_sq[c] = sq;
    row_end = (c + 1 >= w);
    frame_end = row_end && (row_pos + 1 >= h);
    entry = '{s, sq, POS_W'(c), POS_W'(row_pos), frame_end};
    expected_integrals.insert(expected_integrals.size(), entry);
    if (row_end) begin
      run_sum = '0;
      run_sq = '0;
      col_pos = 0;
      row_pos = frame_end ? 0 : row_pos + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [SQ_W-1:0] got,
                             input logic [SQ_W-1:0] exp_v);
    if (got !== exp_v) begin
      report_mismatch($sformatf("%s at row %0d col %0d: got %0d, want %0d",
                                name, want.row, want.column, got, exp_v));
    end
  endtask

  function automatic logic roll_idle(input logic side_active);
    if (idle_mode == IDLE_BOTH) return $urandom_range(0, 99) < 15;
    return side_active && ($urandom_range(0, 99) < 67);
  endfunction

  // pixel driver
  always @(negedge clk) begin
    if (rst) begin
      pixel_ch.valid <= 1'b0;
    end else if (!pixel_ch.valid || pixel_taken) begin
      if (pixel_queue.size() != 0 && !roll_idle(idle_mode == IDLE_SENDER)) begin
        pixel_ch.valid <= 1'b1;
        pixel_ch.pixel <= pixel_queue.pop_front();
      end else begin
        pixel_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver, with a long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (stalls_served != stall_requests) begin
      stalls_served <= stall_requests;
      hold_left <= STALL_CYCLES;
      result_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= !roll_idle(idle_mode == IDLE_RECEIVER);
    end
  end

  // monitor: predict on each pixel item, check each result item
  always @(posedge clk) begin
    if (rst) begin
      pixel_taken <= 1'b0;
    end else begin
      pixel_taken <= pixel_ch.valid && pixel_ch.ready;
      if (pixel_ch.valid && pixel_ch.ready) begin
        integrate_pixel(pixel_ch.pixel);
        pixels_taken++;
      end
      if (result_ch.valid && result_ch.ready) begin
        if (expected_integrals.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          want = expected_integrals.pop_front();
          check_field("area_sum", SQ_W'(result_ch.area_sum), SQ_W'(want.area_sum));
          check_field("area_sum_sq", result_ch.area_sum_sq, want.area_sum_sq);
          check_field("column", SQ_W'(result_ch.column), SQ_W'(want.column));
          check_field("row", SQ_W'(result_ch.row), SQ_W'(want.row));
          check_field("last_of_frame", SQ_W'(result_ch.last_of_frame),
                      SQ_W'(want.last_of_frame));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic drain();
    while (pixels_taken != pixels_queued || expected_integrals.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    if (idx == REG_IMAGE_WIDTH) width_reg = val;
    else height_reg = val;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic start_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                             input idle_mode_t m);
    drain();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    idle_mode = m;
  endtask

  task automatic queue_pixel(input logic [PIX_W-1:0] p);
    pixel_queue.insert(pixel_queue.size(), p);
    pixels_queued++;
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return CFG_W'($urandom);
      3: return CFG_SIZE_RESET;
      default: return CFG_W'($urandom_range(1, 12));
    endcase
  endfunction

  initial begin
    int unsigned phase;
    int unsigned n;
    int unsigned queued_small;
    pixel_ch.valid = 1'b0;
    pixel_ch.pixel = '0;
    result_ch.ready = 1'b0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // zero sizes: every pixel is a frame of its own
    start_phase('0, '0, IDLE_NONE);
    queue_pixel(8'd255); queue_pixel(8'd0); queue_pixel(8'd128);

    start_phase(11'd3, 11'd2, IDLE_SENDER);
    queue_pixel(8'd255); queue_pixel(8'd0); queue_pixel(8'd255);
    queue_pixel(8'd0); queue_pixel(8'd255); queue_pixel(8'd255);

    // narrow the row while the column lies beyond the new last column
    start_phase(11'd4, 11'd3, IDLE_RECEIVER);
    queue_pixel(8'd255); queue_pixel(8'd255); queue_pixel(8'd0);
    queue_pixel(8'd255); queue_pixel(8'd0); queue_pixel(8'd255);
    drain();
    write_reg(REG_IMAGE_WIDTH, 11'd1);
    queue_pixel(8'd255); queue_pixel(8'd0);

    // shorten the frame while the row lies beyond the new last row
    start_phase(11'd2, 11'd4, IDLE_BOTH);
    queue_pixel(8'd255); queue_pixel(8'd255); queue_pixel(8'd0);
    queue_pixel(8'd255); queue_pixel(8'd255);
    drain();
    write_reg(REG_IMAGE_HEIGHT, 11'd1);
    queue_pixel(8'd255);

    // full-width row fills the whole line store; hold the receiver off meanwhile
    start_phase('1, 11'd1, IDLE_NONE);
    stall_requests++;
    repeat (MAX_WIDTH_DEF) queue_pixel(rand_pixel());

    phase = 0;
    queued_small = 0;
    while (queued_small < SMALL_FRAME_ITEMS) begin
      start_phase(rand_size(), rand_size(), idle_mode_t'(phase[1:0]));
      if (phase % 9 == 4) stall_requests++;
      n = $urandom_range(1, 60);
      repeat (n) queue_pixel(rand_pixel());
      queued_small += n;
      phase++;
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
